// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off during reset.
`define VAB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define VAB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

// File: design/vab_pkg.sv
`default_nettype none

package vab_pkg;

   // Field widths.
   localparam int COORD_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;

   // CORDIC depth, limited to the length of the arctangent table.
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 32;
   localparam int STAGE_COUNT   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);

   // Components are scaled by 2^PRESCALE_BITS; three guard bits cover the
   // half-turn negation, the diagonal length and the CORDIC gain.
   localparam int PRESCALE_BITS = 24;
   localparam int CALC_W        = COORD_WIDTH + PRESCALE_BITS + 3;

   // Directions are fractions of a full turn.
   localparam int          TURN_W    = 32;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // Arctangent of 2^-i as a fraction of a full turn.
   localparam logic [TURN_W-1:0] ATAN_TURN [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // One vector on its way through the CORDIC chain.
   typedef struct packed {
      logic signed [CALC_W-1:0] x;
      logic signed [CALC_W-1:0] y;
      logic [TURN_W-1:0]        z;
   } vab_vec_type;

   // What each stage hands to its neighbor.
   typedef struct packed {
      logic        valid;
      logic        zero;
      vab_vec_type a;
      vab_vec_type b;
   } vab_pipe_type;

endpackage

`default_nettype wire

// File: design/vab_prep.sv
`default_nettype none

module vab_prep
   import vab_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] a_x,
   input  wire logic signed [COORD_WIDTH-1:0] a_y,
   input  wire logic signed [COORD_WIDTH-1:0] b_x,
   input  wire logic signed [COORD_WIDTH-1:0] b_y,
   output vab_pipe_type                       pipe_out
);

   logic         valid_ff;
   vab_pipe_type data_ff;
   vab_pipe_type data_in;

   // Scale a vector and turn it by half a turn when it lies left of the y-axis.
   function automatic vab_vec_type vab_start(logic signed [COORD_WIDTH-1:0] cx,
                                             logic signed [COORD_WIDTH-1:0] cy);
      vab_vec_type              v;
      logic signed [CALC_W-1:0] wx;
      logic signed [CALC_W-1:0] wy;
      wx = CALC_W'(cx) <<< PRESCALE_BITS;
      wy = CALC_W'(cy) <<< PRESCALE_BITS;
      if (cx < 0) begin
         v.x = -wx;
         v.y = -wy;
         v.z = HALF_TURN;
      end else begin
         v.x = wx;
         v.y = wy;
         v.z = '0;
      end
      return v;
   endfunction

   // Start values for both vectors and the zero-vector flag.
   always_comb begin
      data_in       = '0;
      data_in.a     = vab_start(a_x, a_y);
      data_in.b     = vab_start(b_x, b_y);
      data_in.zero  = ((a_x == '0) && (a_y == '0)) || ((b_x == '0) && (b_y == '0));
      data_in.valid = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      pipe_out       = data_ff;
      pipe_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

// File: design/vab_cell.sv
`default_nettype none

module vab_cell
   import vab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [STAGE_IDX_W-1:0] stage_idx,
   input  vab_pipe_type                pipe_in,
   output vab_pipe_type                pipe_out
);

   logic         valid_ff;
   vab_pipe_type data_ff;
   vab_pipe_type data_in;

   // One vectoring step: rotate toward the x-axis and account for the angle.
   function automatic vab_vec_type vab_rotate(vab_vec_type v,
                                              logic [STAGE_IDX_W-1:0] idx);
      vab_vec_type              r;
      logic signed [CALC_W-1:0] vx;
      logic signed [CALC_W-1:0] vy;
      logic signed [CALC_W-1:0] dx;
      logic signed [CALC_W-1:0] dy;
      vx = v.x;
      vy = v.y;
      dx = vy >>> idx;
      dy = vx >>> idx;
      if (vy > 0) begin
         r.x = vx + dx;
         r.y = vy - dy;
         r.z = v.z + ATAN_TURN[idx];
      end else begin
         r.x = vx - dx;
         r.y = vy + dy;
         r.z = v.z - ATAN_TURN[idx];
      end
      return r;
   endfunction

   // Both vectors take the same step side by side.
   always_comb begin
      data_in   = pipe_in;
      data_in.a = vab_rotate(pipe_in.a, stage_idx);
      data_in.b = vab_rotate(pipe_in.b, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pipe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      pipe_out       = data_ff;
      pipe_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

// File: design/vab_finish.sv
`default_nettype none

module vab_finish
   import vab_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  vab_pipe_type                 pipe_in,
   output logic                         out_valid,
   output logic [ANGLE_WIDTH-1:0]       out_angle,
   output logic                         out_zero
);

   localparam int                ROUND_SHIFT = TURN_W - ANGLE_WIDTH;
   localparam logic [TURN_W:0]   HALF_LSB    = (TURN_W + 1)'((64'd1 << ROUND_SHIFT) >> 1);

   logic                   valid_ff;
   logic [ANGLE_WIDTH-1:0] angle_ff;
   logic [ANGLE_WIDTH-1:0] angle_in;
   logic                   zero_ff;
   logic [TURN_W-1:0]      diff;
   logic [TURN_W:0]        rounded;

   // Difference of the two directions modulo a turn, rounded half-up.
   always_comb begin
      diff    = pipe_in.b.z - pipe_in.a.z;
      rounded = {1'b0, diff} + HALF_LSB;
      if (pipe_in.zero) begin
         angle_in = '0;
      end else begin
         angle_in = rounded[ROUND_SHIFT +: ANGLE_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pipe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
         zero_ff  <= pipe_in.zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;
   assign out_zero  = zero_ff;

endmodule

`default_nettype wire

// File: design/vector_angle_between_2d.sv
// Counter-clockwise angle from vector a to vector b, as a fraction of a turn.
// Request channel: req_valid/req_ready with req_a_x, req_a_y, req_b_x, req_b_y,
// each a signed 16-bit component. Result channel: rsp_valid/rsp_ready with
// rsp_angle (unsigned, units of 2pi/65536) and rsp_zero_vector, which is set
// with an angle of 0 when either vector is (0, 0).
// Each request runs through an input stage, a chain of 16 CORDIC cells that
// rotate both vectors one step per cell, and an output register. While the
// receiver does not stall, the chain takes one request every cycle;
// throughput is one result per cycle.
// When the receiver stalls with a result waiting, the whole chain holds and
// req_ready drops in the same cycle; it rises again as soon as the waiting
// result is taken, and no request is lost or repeated.
// A synchronous reset empties the chain: rsp_valid is low after reset, and
// the block takes requests in the first cycle after reset.

`default_nettype none

`include "assert_macros.svh"

module vector_angle_between_2d
   import vab_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ANGLE_WIDTH-1:0]             rsp_angle,
   output logic                               rsp_zero_vector
);

   logic         advance;
   vab_pipe_type pipe [STAGE_COUNT+1];

   // The chain moves unless a finished result is waiting for the receiver.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Input stage: scaling, half-plane turn and zero-vector test.
   vab_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .pipe_out (pipe[0])
   );

   // Chain of CORDIC cells, one per table entry in use.
   for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
      vab_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (STAGE_IDX_W'(g)),
         .pipe_in   (pipe[g]),
         .pipe_out  (pipe[g+1])
      );
   end

   // Angle difference, rounding and the result register.
   vab_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pipe_in   (pipe[STAGE_COUNT]),
      .out_valid (rsp_valid),
      .out_angle (rsp_angle),
      .out_zero  (rsp_zero_vector)
   );

   // Checks on the chain.
   `VAB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
   `VAB_ASSERT(a_zero_angle, rsp_valid && rsp_zero_vector |-> rsp_angle == '0, "angle not zero")
   `VAB_ASSERT(a_handoff, pipe[STAGE_COUNT].valid && advance |=> rsp_valid, "last cell result dropped")
   `VAB_ASSERT(a_stall_holds, !advance |=> $stable(pipe[0].valid), "input stage moved during stall")

endmodule

`default_nettype wire
